FILE: sv/triangle_barycentric_weights_core_defines.svh
// ----------------------------------------------------------------------------
// barycentric weights core assertion macros
// shared assertion forms for the rtl
// ----------------------------------------------------------------------------
`ifndef TRIANGLE_BARYCENTRIC_WEIGHTS_CORE_DEFINES_SVH
`define TRIANGLE_BARYCENTRIC_WEIGHTS_CORE_DEFINES_SVH

// implication checked on every clock, idle in reset
`define TBW_ASSERT_IMPL(label, clk, rstn, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
        else $error("assertion failed");

// next-cycle implication
`define TBW_ASSERT_NEXT(label, clk, rstn, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
        else $error("assertion failed");

`endif

FILE: sv/tbw_pkg.sv
// ----------------------------------------------------------------------------
// barycentric weights package
// shared widths
// ----------------------------------------------------------------------------
package tbw_pkg;
    localparam int unsigned WEIGHT_BITS = 32;
    localparam int unsigned OUT_TDATA_BITS = 104;
endpackage

FILE: sv/tbw_front.sv
// ----------------------------------------------------------------------------
// barycentric weights front
// unpacks a request, forms the edge and point-to-vertex vectors
// ----------------------------------------------------------------------------
module tbw_front
    import tbw_pkg::*;
#(
    parameter int COORD_BITS = 16
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [12*COORD_BITS-1:0] in_data,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [COORD_BITS:0]      e1_x, e1_y, e1_z,
    output logic [COORD_BITS:0]      e2_x, e2_y, e2_z,
    output logic [COORD_BITS:0]      e3_x, e3_y, e3_z,
    output logic [COORD_BITS:0]      d1_x, d1_y, d1_z,
    output logic [COORD_BITS:0]      d2_x, d2_y, d2_z,
    output logic [COORD_BITS:0]      d3_x, d3_y, d3_z
);
    localparam int DW = COORD_BITS + 1;
    logic valid_reg;
    logic signed [DW-1:0] v_reg [18];
    logic signed [DW-1:0] c [12];

    assign in_ready = !valid_reg || out_ready;
    assign out_valid = valid_reg;

    always_comb begin
        for (int i = 0; i < 12; i++) begin
            c[i] = DW'($signed(in_data[i*COORD_BITS +: COORD_BITS]));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
        if (in_ready && in_valid) begin
            for (int k = 0; k < 3; k++) begin
                v_reg[k]    <= c[3+k] - c[6+k];
                v_reg[3+k]  <= c[6+k] - c[k];
                v_reg[6+k]  <= c[k] - c[3+k];
                v_reg[9+k]  <= c[9+k] - c[k];
                v_reg[12+k] <= c[9+k] - c[3+k];
                v_reg[15+k] <= c[9+k] - c[6+k];
            end
        end
    end

    assign e1_x = v_reg[0];  assign e1_y = v_reg[1];  assign e1_z = v_reg[2];
    assign e2_x = v_reg[3];  assign e2_y = v_reg[4];  assign e2_z = v_reg[5];
    assign e3_x = v_reg[6];  assign e3_y = v_reg[7];  assign e3_z = v_reg[8];
    assign d1_x = v_reg[9];  assign d1_y = v_reg[10]; assign d1_z = v_reg[11];
    assign d2_x = v_reg[12]; assign d2_y = v_reg[13]; assign d2_z = v_reg[14];
    assign d3_x = v_reg[15]; assign d3_y = v_reg[16]; assign d3_z = v_reg[17];
endmodule

FILE: sv/tbw_back.sv
// ----------------------------------------------------------------------------
// barycentric weights back
// cross and dot products, then a pipelined restoring divider per weight
// ----------------------------------------------------------------------------
`include "triangle_barycentric_weights_core_defines.svh"
module tbw_back
    import tbw_pkg::*;
#(
    parameter int COORD_BITS = 16,
    parameter int WEIGHT_FRAC_BITS = 16
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [COORD_BITS:0]       e1_x, e1_y, e1_z,
    input  logic [COORD_BITS:0]       e2_x, e2_y, e2_z,
    input  logic [COORD_BITS:0]       e3_x, e3_y, e3_z,
    input  logic [COORD_BITS:0]       d1_x, d1_y, d1_z,
    input  logic [COORD_BITS:0]       d2_x, d2_y, d2_z,
    input  logic [COORD_BITS:0]       d3_x, d3_y, d3_z,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [WEIGHT_BITS-1:0]    weight_a,
    output logic [WEIGHT_BITS-1:0]    weight_b,
    output logic [WEIGHT_BITS-1:0]    weight_c,
    output logic                      degenerate
);
    localparam int DW = COORD_BITS + 1;
    localparam int CW = 2*DW + 1;        // cross product
    localparam int NW = 2*CW + 2;        // dot product
    localparam int UW = NW + WEIGHT_FRAC_BITS;  // dividend magnitude
    localparam int QB = WEIGHT_BITS + 1;  // quotient bits kept
    localparam int ST = 4 + QB;          // pipeline depth

    logic stall;
    assign stall = out_valid && !out_ready;
    assign in_ready = !stall;
    logic adv;
    assign adv = !stall;

    logic [ST-1:0] vld_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) vld_reg <= '0;
        else if (adv) vld_reg <= {vld_reg[ST-2:0], in_valid};
    end
    assign out_valid = vld_reg[ST-1];

    // stage 1: products for normal n = e2 x e1 and the three cross vectors
    logic signed [CW-1:0] n_reg [3];
    logic signed [CW-1:0] x_reg [3][3];
    function automatic logic signed [CW-1:0] xc(input logic signed [DW-1:0] a,
        input logic signed [DW-1:0] b, input logic signed [DW-1:0] c,
        input logic signed [DW-1:0] d);
        xc = CW'(a*b) - CW'(c*d);
    endfunction
    always_ff @(posedge aclk) begin
        if (adv) begin
            n_reg[0] <= xc(e2_y, e1_z, e2_z, e1_y);
            n_reg[1] <= xc(e2_z, e1_x, e2_x, e1_z);
            n_reg[2] <= xc(e2_x, e1_y, e2_y, e1_x);
            x_reg[0][0] <= xc(e1_y, d3_z, e1_z, d3_y);
            x_reg[0][1] <= xc(e1_z, d3_x, e1_x, d3_z);
            x_reg[0][2] <= xc(e1_x, d3_y, e1_y, d3_x);
            x_reg[1][0] <= xc(e2_y, d1_z, e2_z, d1_y);
            x_reg[1][1] <= xc(e2_z, d1_x, e2_x, d1_z);
            x_reg[1][2] <= xc(e2_x, d1_y, e2_y, d1_x);
            x_reg[2][0] <= xc(e3_y, d2_z, e3_z, d2_y);
            x_reg[2][1] <= xc(e3_z, d2_x, e3_x, d2_z);
            x_reg[2][2] <= xc(e3_x, d2_y, e3_y, d2_x);
        end
    end

    // stage 2: dot products term by term
    logic signed [NW-1:0] pd_reg [4][3];
    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int k = 0; k < 3; k++) begin
                pd_reg[3][k] <= NW'(n_reg[k] * n_reg[k]);
                for (int w = 0; w < 3; w++) pd_reg[w][k] <= NW'(x_reg[w][k] * n_reg[k]);
            end
        end
    end

    // stage 3: sums
    logic signed [NW-1:0] s_reg [4];
    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int w = 0; w < 4; w++) s_reg[w] <= pd_reg[w][0] + pd_reg[w][1] + pd_reg[w][2];
        end
    end

    // stage 4: magnitudes, shift, early saturation detect
    logic          neg_reg [ST][3];
    logic          big_reg [ST][3];
    logic [NW-1:0] den_reg [ST];
    logic          dg_reg  [ST];
    logic [QB-1:0] q_reg   [ST][3];
    logic [NW-1:0] r_reg   [ST][3];
    logic [UW-1:0] nm_reg  [ST][3];

    always_ff @(posedge aclk) begin
        if (adv) begin
            den_reg[3] <= s_reg[3];
            dg_reg[3]  <= (s_reg[3] == '0);
            for (int w = 0; w < 3; w++) begin
                logic [UW-1:0] m;
                m = {(s_reg[w][NW-1] ? NW'(-s_reg[w]) : s_reg[w]),
                     {WEIGHT_FRAC_BITS{1'b0}}};
                neg_reg[3][w] <= s_reg[w][NW-1];
                // quotient >= 2^QB iff m >> QB >= den
                big_reg[3][w] <= ((m >> QB) >= UW'(s_reg[3]));
                nm_reg[3][w]  <= m;
                r_reg[3][w]   <= '0;
                q_reg[3][w]   <= '0;
            end
        end
    end

    // restoring division, one quotient bit per stage (low QB bits only)
    for (genvar s = 4; s < ST; s++) begin : g_div
        localparam int BIT = ST - 1 - s;
        always_ff @(posedge aclk) begin
            if (adv) begin
                den_reg[s] <= den_reg[s-1];
                dg_reg[s]  <= dg_reg[s-1];
                for (int w = 0; w < 3; w++) begin
                    logic [NW:0] t;
                    logic [UW-1:0] rem_full;
                    if (s == 4) begin
                        // partial remainder of the high bits: m[UW-1:QB] mod den
                        // is below den once big is false; take it directly
                        rem_full = nm_reg[s-1][w] >> QB;
                        t = {rem_full[NW-1:0], nm_reg[s-1][w][BIT]};
                    end else begin
                        t = {r_reg[s-1][w], nm_reg[s-1][w][BIT]};
                    end
                    neg_reg[s][w] <= neg_reg[s-1][w];
                    big_reg[s][w] <= big_reg[s-1][w];
                    nm_reg[s][w]  <= nm_reg[s-1][w];
                    if (t >= {1'b0, den_reg[s-1]}) begin
                        r_reg[s][w] <= NW'(t - {1'b0, den_reg[s-1]});
                        q_reg[s][w] <= q_reg[s-1][w] | (QB'(1) << BIT);
                    end else begin
                        r_reg[s][w] <= t[NW-1:0];
                        q_reg[s][w] <= q_reg[s-1][w];
                    end
                end
            end
        end
    end

    // saturation and sign on the last stage
    function automatic logic [WEIGHT_BITS-1:0] fin(input logic [QB-1:0] q,
        input logic n, input logic b);
        if (!n) fin = (b || q > QB'(32'h7FFFFFFF)) ? 32'h7FFFFFFF : q[WEIGHT_BITS-1:0];
        else fin = (b || q > QB'(32'h80000000)) ? 32'h80000000
                                                : WEIGHT_BITS'(-q);
    endfunction
    logic dg;
    assign dg = dg_reg[ST-1];
    assign degenerate = dg;
    assign weight_a = dg ? '0 : fin(q_reg[ST-1][0], neg_reg[ST-1][0], big_reg[ST-1][0]);
    assign weight_b = dg ? '0 : fin(q_reg[ST-1][1], neg_reg[ST-1][1], big_reg[ST-1][1]);
    assign weight_c = dg ? '0 : fin(q_reg[ST-1][2], neg_reg[ST-1][2], big_reg[ST-1][2]);

    `TBW_ASSERT_IMPL(a_degen_zero, aclk, aresetn, out_valid && degenerate, (weight_a | weight_b | weight_c) == '0)
    `TBW_ASSERT_NEXT(a_hold, aclk, aresetn, out_valid && !out_ready, out_valid)
    `TBW_ASSERT_IMPL(a_ready, aclk, aresetn, !out_valid, in_ready)
endmodule

FILE: sv/triangle_barycentric_weights_core.sv
// ----------------------------------------------------------------------------
// triangle barycentric weights core
// barycentric weights of a point against a 3-d triangle, streaming
// ----------------------------------------------------------------------------
// channel   direction  contents
// s_axis    in         12 coordinates ax..pz, 16 bits each
// m_axis    out        weight_a, weight_b, weight_c, degenerate
//
// one request per cycle while m_axis is not stalled; 1 front stage plus 37 back
// stages, most of them in the one-bit-per-stage divider
// reset clears the valid bits only, payload registers run free
// a stall on m_axis freezes the back and through it the front, no request is lost
module triangle_barycentric_weights_core
    import tbw_pkg::*;
#(
    parameter int COORD_BITS = 16,
    parameter int WEIGHT_FRAC_BITS = 16
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    // ax, ay, az, bx, by, bz, cx, cy, cz, px, py, pz from the lowest bit up
    input  logic [12*COORD_BITS-1:0]   s_axis_tdata,
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    // weight_a, weight_b, weight_c, degenerate from the lowest bit up, zero fill
    output logic [OUT_TDATA_BITS-1:0]  m_axis_tdata
);
    logic              f_valid, f_ready;
    logic [COORD_BITS:0] e1x, e1y, e1z, e2x, e2y, e2z, e3x, e3y, e3z;
    logic [COORD_BITS:0] d1x, d1y, d1z, d2x, d2y, d2z, d3x, d3y, d3z;
    logic [WEIGHT_BITS-1:0] wa, wb, wc;
    logic dg;

    // front: edge and point-to-vertex vectors
    tbw_front #(.COORD_BITS(COORD_BITS)) u_front (
        .aclk, .aresetn,
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_data(s_axis_tdata),
        .out_valid(f_valid), .out_ready(f_ready),
        .e1_x(e1x), .e1_y(e1y), .e1_z(e1z), .e2_x(e2x), .e2_y(e2y), .e2_z(e2z),
        .e3_x(e3x), .e3_y(e3y), .e3_z(e3z), .d1_x(d1x), .d1_y(d1y), .d1_z(d1z),
        .d2_x(d2x), .d2_y(d2y), .d2_z(d2z), .d3_x(d3x), .d3_y(d3y), .d3_z(d3z)
    );

    // back: products, sums and division
    tbw_back #(.COORD_BITS(COORD_BITS), .WEIGHT_FRAC_BITS(WEIGHT_FRAC_BITS)) u_back (
        .aclk, .aresetn,
        .in_valid(f_valid), .in_ready(f_ready),
        .e1_x(e1x), .e1_y(e1y), .e1_z(e1z), .e2_x(e2x), .e2_y(e2y), .e2_z(e2z),
        .e3_x(e3x), .e3_y(e3y), .e3_z(e3z), .d1_x(d1x), .d1_y(d1y), .d1_z(d1z),
        .d2_x(d2x), .d2_y(d2y), .d2_z(d2z), .d3_x(d3x), .d3_y(d3y), .d3_z(d3z),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
        .weight_a(wa), .weight_b(wb), .weight_c(wc), .degenerate(dg)
    );

    assign m_axis_tdata = {7'b0, dg, wc, wb, wa};
endmodule

FILE: sim/testbench.sv
// ----------------------------------------------------------------------------
// barycentric weights core testbench
// streams triangle and point requests through the core under random idling
// and compares every weight set with an exact integer model kept here
// ----------------------------------------------------------------------------
module testbench
    import tbw_pkg::*;
();

    localparam int COORD_BITS = 16;
    localparam int FRAC = 16;
    localparam int NRAND = 1700;
    localparam int LATENCY = 40;

    typedef struct packed {
        logic [31:0] wa;
        logic [31:0] wb;
        logic [31:0] wc;
        logic        degen;
    } weights_t;

    typedef struct {
        logic [12*COORD_BITS-1:0] coords;
        bit                       has_weights;
        weights_t                 weights;
    } stim_row_t;

    logic aclk;
    logic aresetn;
    logic s_axis_tvalid;
    logic s_axis_tready;
    // ax, ay, az, bx, by, bz, cx, cy, cz, px, py, pz from the lowest bit up
    logic [12*COORD_BITS-1:0] s_axis_tdata;
    logic m_axis_tvalid;
    logic m_axis_tready;
    // weight_a, weight_b, weight_c, degenerate from the lowest bit up
    logic [OUT_TDATA_BITS-1:0] m_axis_tdata;

    weights_t expected_weights[$];
    int mismatches;
    int weight_sets_seen;
    int degenerate_seen;
    int send_idle_pct;
    int recv_stall_pct;

    triangle_barycentric_weights_core #(
        .COORD_BITS(COORD_BITS),
        .WEIGHT_FRAC_BITS(FRAC)
    ) uut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // one weight: ((edge x dv) . n) << FRAC / (n . n), truncated and saturated
    function automatic logic [31:0] weight_quotient(input logic signed [191:0] num,
                                                    input logic signed [191:0] den);
        logic signed [191:0] mag;
        logic signed [191:0] q;
        bit neg;
        neg = num < 0;
        mag = neg ? -num : num;
        q = (mag <<< FRAC) / den;
        if (!neg) return (q > 192'sh7FFFFFFF) ? 32'h7FFFFFFF : q[31:0];
        if (q > 192'sh80000000) return 32'h80000000;
        return -q[31:0];
    endfunction

    function automatic weights_t barycentric_weights(input logic [12*COORD_BITS-1:0] coords);
        logic signed [191:0] v[12];
        logic signed [191:0] e1[3], e2[3], e3[3], d1[3], d2[3], d3[3], n[3];
        logic signed [191:0] den, num_a, num_b, num_c;
        weights_t w;
        for (int i = 0; i < 12; i++)
            v[i] = 192'(signed'(coords[i*COORD_BITS +: COORD_BITS]));
        for (int k = 0; k < 3; k++) begin
            e1[k] = v[3+k] - v[6+k];
            e2[k] = v[6+k] - v[k];
            e3[k] = v[k] - v[3+k];
            d1[k] = v[9+k] - v[k];
            d2[k] = v[9+k] - v[3+k];
            d3[k] = v[9+k] - v[6+k];
        end
        // normal n = e2 x e1
        n[0] = e2[1]*e1[2] - e2[2]*e1[1];
        n[1] = e2[2]*e1[0] - e2[0]*e1[2];
        n[2] = e2[0]*e1[1] - e2[1]*e1[0];
        den = n[0]*n[0] + n[1]*n[1] + n[2]*n[2];
        w = '0;
        if (den == 0) begin
            w.degen = 1'b1;
            return w;
        end
        num_a = (e1[1]*d3[2] - e1[2]*d3[1])*n[0] + (e1[2]*d3[0] - e1[0]*d3[2])*n[1]
              + (e1[0]*d3[1] - e1[1]*d3[0])*n[2];
        num_b = (e2[1]*d1[2] - e2[2]*d1[1])*n[0] + (e2[2]*d1[0] - e2[0]*d1[2])*n[1]
              + (e2[0]*d1[1] - e2[1]*d1[0])*n[2];
        num_c = (e3[1]*d2[2] - e3[2]*d2[1])*n[0] + (e3[2]*d2[0] - e3[0]*d2[2])*n[1]
              + (e3[0]*d2[1] - e3[1]*d2[0])*n[2];
        w.wa = weight_quotient(num_a, den);
        w.wb = weight_quotient(num_b, den);
        w.wc = weight_quotient(num_c, den);
        return w;
    endfunction

    function automatic logic [12*COORD_BITS-1:0] pack_coords(input int c[12]);
        logic [12*COORD_BITS-1:0] r;
        for (int i = 0; i < 12; i++) r[i*COORD_BITS +: COORD_BITS] = c[i][15:0];
        return r;
    endfunction

    // random triangle: half with small coordinates so weights stay in range,
    // some full range, some with shared vertices or collinear points
    function automatic logic [12*COORD_BITS-1:0] random_request();
        int c[12];
        int mode;
        int span;
        mode = $urandom_range(0, 9);
        span = (mode < 5) ? 1024 : 32767;
        for (int i = 0; i < 12; i++) c[i] = $urandom_range(0, 2*span) - span;
        if (mode == 8) begin
            // collinear: c = a + 2(b - a), small enough to stay in range
            for (int k = 0; k < 3; k++) begin
                c[k] = $urandom_range(0, 2000) - 1000;
                c[3+k] = $urandom_range(0, 2000) - 1000;
                c[6+k] = 2*c[3+k] - c[k];
            end
        end else if (mode == 9) begin
            // point near the centroid, the truncated mean of the vertices
            for (int k = 0; k < 3; k++) c[9+k] = (c[k] + c[3+k] + c[6+k]) / 3;
        end
        if (mode == 7 && $urandom_range(0, 1)) begin
            for (int k = 0; k < 3; k++) c[6+k] = c[k];
        end
        return pack_coords(c);
    endfunction

    // directed rows: expected weights typed in only for the obvious ones
    function automatic stim_row_t row(input int c[12], input bit known, input weights_t w);
        stim_row_t r;
        r.coords = pack_coords(c);
        r.has_weights = known;
        r.weights = w;
        return r;
    endfunction

    stim_row_t directed[$];

    task automatic send_request(input logic [12*COORD_BITS-1:0] coords);
        while (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= coords;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        expected_weights.push_back(barycentric_weights(coords));
        @(negedge aclk);
    endtask

    // receiver side: random stalls driven at the falling edge
    always @(negedge aclk) begin
        m_axis_tready <= !(recv_stall_pct > 0 && $urandom_range(0, 99) < recv_stall_pct);
    end

    // result checker at the rising edge
    always @(posedge aclk) begin
        weights_t got;
        weights_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got = {m_axis_tdata[31:0], m_axis_tdata[63:32], m_axis_tdata[95:64],
                   m_axis_tdata[96]};
            weight_sets_seen++;
            if (got.degen) degenerate_seen++;
            if (expected_weights.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected weight set %h", got);
            end else begin
                want = expected_weights.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: a %h/%h b %h/%h c %h/%h degen %b/%b (exp/got)",
                                 want.wa, got.wa, want.wb, got.wb, want.wc, got.wc,
                                 want.degen, got.degen);
                end
            end
        end
    end

    initial begin
        #4000000;
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        int c[12];
        weights_t w;
        int phase;
        mismatches = 0;
        weight_sets_seen = 0;
        degenerate_seen = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        aresetn = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // all zero: degenerate
        w = '0; w.degen = 1'b1;
        c = '{default: 0};
        directed.push_back(row(c, 1, w));
        // all coordinates at the extremes: degenerate
        c = '{default: -32768};
        directed.push_back(row(c, 1, w));
        c = '{default: 32767};
        directed.push_back(row(c, 1, w));
        // unit right triangle, point at each vertex
        w = '0;
        c = '{0, 0, 0, 256, 0, 0, 0, 256, 0, 0, 0, 0};
        w.wa = 32'h10000;
        directed.push_back(row(c, 1, w));
        c = '{0, 0, 0, 256, 0, 0, 0, 256, 0, 256, 0, 0};
        w = '0; w.wb = 32'h10000;
        directed.push_back(row(c, 1, w));
        c = '{0, 0, 0, 256, 0, 0, 0, 256, 0, 0, 256, 0};
        w = '0; w.wc = 32'h10000;
        directed.push_back(row(c, 1, w));
        // point off the plane and outside the triangle
        c = '{0, 0, 0, 256, 0, 0, 0, 256, 0, 64, 64, 999};
        directed.push_back(row(c, 0, w));
        c = '{0, 0, 0, 256, 0, 0, 0, 256, 0, -512, 900, 0};
        directed.push_back(row(c, 0, w));
        // tiny triangle with far point: saturation both ways
        c = '{0, 0, 0, 1, 0, 0, 0, 1, 0, 32767, 32767, 0};
        directed.push_back(row(c, 0, w));
        c = '{0, 0, 0, 1, 0, 0, 0, 1, 0, -32768, -32768, 0};
        directed.push_back(row(c, 0, w));
        // largest triangle
        c = '{-32768, -32768, -32768, 32767, -32768, 32767, -32768, 32767, 32767,
              32767, 32767, -32768};
        directed.push_back(row(c, 0, w));
        c = '{32767, -32768, 0, -32768, 32767, 0, 0, 0, 32767, -32768, -32768, -32768};
        directed.push_back(row(c, 0, w));
        // collinear and shared vertices: degenerate
        w = '0; w.degen = 1'b1;
        c = '{0, 0, 0, 100, 100, 100, 200, 200, 200, 5, 6, 7};
        directed.push_back(row(c, 1, w));
        c = '{10, 20, 30, 10, 20, 30, -5, 7, 1000, 1, 2, 3};
        directed.push_back(row(c, 1, w));
        // alternating bit patterns on every field
        c = '{default: 16'h5555};
        c[3] = 16'hAAAA; c[7] = 16'hAAAA; c[11] = 16'hAAAA;
        directed.push_back(row(c, 0, w));
        c = '{default: 16'hAAAA - 65536};
        c[1] = 16'h5555; c[5] = 16'h5555; c[9] = 16'h5555;
        directed.push_back(row(c, 0, w));

        foreach (directed[i]) begin
            if (directed[i].has_weights &&
                barycentric_weights(directed[i].coords) !== directed[i].weights) begin
                mismatches++;
                $display("directed row %0d: model disagrees with table", i);
            end
            send_request(directed[i].coords);
        end

        // random part over the idling phases, last one without idling
        for (int i = 0; i < NRAND; i++) begin
            phase = (i * 5) / NRAND;
            case (phase)
                0: begin send_idle_pct = 0; recv_stall_pct = 0; end
                1: begin send_idle_pct = 63; recv_stall_pct = 0; end
                2: begin send_idle_pct = 0; recv_stall_pct = 63; end
                3: begin send_idle_pct = 16; recv_stall_pct = 16; end
                default: begin send_idle_pct = 0; recv_stall_pct = 0; end
            endcase
            send_request(random_request());
        end
        s_axis_tvalid <= 1'b0;

        while (expected_weights.size() != 0) @(posedge aclk);
        repeat (LATENCY) @(posedge aclk);

        $display("sent %0d triangle requests, got %0d weight sets, %0d degenerate",
                 directed.size() + NRAND, weight_sets_seen, degenerate_seen);
        $display("idling phases: none, sender, receiver, both; mismatches %0d", mismatches);
        if (mismatches == 0 && expected_weights.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
